// ===== rtl/core/cdc_pkg.sv =====
// Shared types, constants and small helper functions for the calendar date converter.
// Used by the channel interfaces, the shared adder, the year tracker, the top level and checker.
package cdc_pkg;

  typedef logic [11:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  day_t;
  typedef logic [16:0] daynum_t;
  typedef logic [17:0] acc_t;
  typedef logic [2:0]  wday_t;
  typedef logic [1:0]  status_t;

  localparam year_t FIRST_YEAR = 12'd1970;
  localparam year_t LAST_YEAR  = 12'd2199;
  localparam year_t EPOCH_YEAR = 12'd1970;

  localparam int unsigned EPOCH_MOD100 = 1970 % 100;
  localparam int unsigned EPOCH_MOD400 = 1970 % 400;

  localparam wday_t EPOCH_WDAY = 3'd4;
  localparam logic [8:0] YEAR_DAYS = 9'd365;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_BAD_DAY = 2'd1;
  localparam status_t ST_RANGE   = 2'd2;

  localparam logic CMD_TO_DAYS = 1'b0;
  localparam logic CMD_TO_DATE = 1'b1;

  localparam month_t MONTH_FIRST = 4'd1;
  localparam month_t MONTH_LAST  = 4'd12;
  localparam month_t MONTH_FEB   = 4'd2;

  typedef struct packed {
    acc_t a;
    acc_t b;
    logic sub;
  } alu_req_t;

  typedef struct packed {
    logic init;
    logic step;
  } cal_ctrl_t;

  function automatic day_t days_of_month(input logic leap, input month_t mo);
    day_t len;
    case (mo)
      MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic wday_t mod7(input day_t x);
    day_t v;
    v = x;
    if (v >= 5'd28) v = v - 5'd28;
    if (v >= 5'd14) v = v - 5'd14;
    if (v >= 5'd7)  v = v - 5'd7;
    return v[2:0];
  endfunction

  function automatic wday_t wday_add(input wday_t wd, input day_t k);
    logic [3:0] s;
    s = {1'b0, wd} + {1'b0, mod7(k)};
    if (s >= 4'd7) s = s - 4'd7;
    return s[2:0];
  endfunction

endpackage

// ===== rtl/core/cdc_if.sv =====
// Valid/ready channel interfaces for request items and result items.
// Depends on cdc_pkg for the field types.
interface cdc_in_if import cdc_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    command;
  year_t   in_year;
  month_t  in_month;
  day_t    in_day;
  daynum_t in_day_number;

  modport source (output valid, command, in_year, in_month, in_day, in_day_number,
                  input ready);
  modport sink (input valid, command, in_year, in_month, in_day, in_day_number,
                output ready);
endinterface

interface cdc_out_if import cdc_pkg::*; ();
  logic    valid;
  logic    ready;
  daynum_t out_day_number;
  year_t   out_year;
  month_t  out_month;
  day_t    out_day;
  wday_t   weekday;
  status_t status;

  modport source (output valid, out_day_number, out_year, out_month, out_day, weekday,
                  status, input ready);
  modport sink (input valid, out_day_number, out_year, out_month, out_day, weekday,
                status, output ready);
endinterface

// ===== rtl/core/cdc_alu.sv =====
// Shared add/subtract unit used for every year, month and day step of a conversion.
// Depends on cdc_pkg for the request struct.
module cdc_alu import cdc_pkg::*; (
  input  alu_req_t req,
  output acc_t     res,
  output logic     carry
);

  logic [18:0] full;

  always_comb begin
    if (req.sub) begin
      full = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      full = {1'b0, req.a} + {1'b0, req.b};
    end
  end

  assign res   = full[17:0];
  assign carry = full[18];

endmodule

// ===== rtl/core/cdc_cal.sv =====
// Year counter that walks forward from the epoch and tracks the Gregorian leap rule.
// Depends on cdc_pkg for types and epoch constants.
module cdc_cal import cdc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cal_ctrl_t  ctrl,
  output year_t      year,
  output logic       leap,
  output logic [8:0] year_len
);

  year_t      yr_r, yr_nxt;
  logic [6:0] c100_r, c100_nxt;
  logic [8:0] c400_r, c400_nxt;

  always_comb begin
    yr_nxt   = yr_r;
    c100_nxt = c100_r;
    c400_nxt = c400_r;
    if (ctrl.init) begin
      yr_nxt   = EPOCH_YEAR;
      c100_nxt = 7'(EPOCH_MOD100);
      c400_nxt = 9'(EPOCH_MOD400);
    end else if (ctrl.step) begin
      yr_nxt   = yr_r + 12'd1;
      c100_nxt = (c100_r == 7'd99) ? 7'd0 : c100_r + 7'd1;
      c400_nxt = (c400_r == 9'd399) ? 9'd0 : c400_r + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yr_r   <= EPOCH_YEAR;
      c100_r <= 7'(EPOCH_MOD100);
      c400_r <= 9'(EPOCH_MOD400);
    end else begin
      yr_r   <= yr_nxt;
      c100_r <= c100_nxt;
      c400_r <= c400_nxt;
    end
  end

  assign year     = yr_r;
  assign leap     = ((yr_r[1:0] == 2'd0) && (c100_r != 7'd0)) || (c400_r == 9'd0);
  assign year_len = YEAR_DAYS + {8'd0, leap};

endmodule

// ===== rtl/core/calendar_date_day_number_converter.sv =====
// Top level of the Gregorian date to day number converter and its inverse.
// Depends on cdc_pkg, cdc_if, cdc_alu and cdc_cal.

// Each item either turns a year, month and day into days since 1970-01-01 or turns a day
// number back into a date, and always returns one result item with the weekday (0 is Sunday)
// and a status. Work is done by one shared adder that steps one year per cycle from 1970 and
// then one month per cycle. The input is ready again in the cycle after the result is loaded.
// The block takes one item at a time; a finished result waits in the output register while
// the next item is worked on.
module calendar_date_day_number_converter import cdc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  cdc_in_if.sink    in_ch,
  cdc_out_if.source out_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_YEAR  = 3'd1;
  localparam logic [2:0] S_MONTH = 3'd2;
  localparam logic [2:0] S_DAYS  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       cmd_r, cmd_nxt;
  year_t      y_r, y_nxt;
  month_t     m_r, m_nxt;
  day_t       d_r, d_nxt;
  daynum_t    n_r, n_nxt;
  acc_t       acc_r, acc_nxt;
  month_t     mo_r, mo_nxt;
  wday_t      wd_r, wd_nxt;
  logic       ovf_r, ovf_nxt;
  status_t    st_r, st_nxt;

  logic       out_valid_r;
  daynum_t    out_num_r;
  year_t      out_year_r;
  month_t     out_month_r;
  day_t       out_day_r;
  wday_t      out_wday_r;
  status_t    out_status_r;

  alu_req_t   alu_req;
  acc_t       alu_res;
  logic       alu_carry;
  cal_ctrl_t  cal_ctrl;
  year_t      cal_year;
  logic       cal_leap;
  logic [8:0] cal_ylen;
  day_t       mlen;
  day_t       ymod;
  logic       load;
  logic       ok;

  cdc_alu u_alu (
    .req   (alu_req),
    .res   (alu_res),
    .carry (alu_carry)
  );

  cdc_cal u_cal (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (cal_ctrl),
    .year     (cal_year),
    .leap     (cal_leap),
    .year_len (cal_ylen)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign load        = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign mlen        = days_of_month(cal_leap, (state_r == S_YEAR) ? m_r : mo_r);
  assign ymod        = cal_leap ? 5'd2 : 5'd1;

  always_comb begin
    alu_req.a   = acc_r;
    alu_req.sub = (cmd_r == CMD_TO_DATE);
    unique case (state_r)
      S_YEAR:  alu_req.b = {9'd0, cal_ylen};
      S_MONTH: alu_req.b = {13'd0, mlen};
      default: alu_req.b = {13'd0, d_r - 5'd1};
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    y_nxt         = y_r;
    m_nxt         = m_r;
    d_nxt         = d_r;
    n_nxt         = n_r;
    acc_nxt       = acc_r;
    mo_nxt        = mo_r;
    wd_nxt        = wd_r;
    ovf_nxt       = ovf_r;
    st_nxt        = st_r;
    cal_ctrl.init = 1'b0;
    cal_ctrl.step = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt       = in_ch.command;
          y_nxt         = in_ch.in_year;
          m_nxt         = in_ch.in_month;
          d_nxt         = in_ch.in_day;
          n_nxt         = in_ch.in_day_number;
          acc_nxt       = (in_ch.command == CMD_TO_DATE) ? {1'b0, in_ch.in_day_number} : '0;
          mo_nxt        = MONTH_FIRST;
          wd_nxt        = EPOCH_WDAY;
          ovf_nxt       = 1'b0;
          st_nxt        = ST_OK;
          cal_ctrl.init = 1'b1;
          state_nxt     = S_YEAR;
          if ((in_ch.command == CMD_TO_DAYS) &&
              ((in_ch.in_year < FIRST_YEAR) || (in_ch.in_year > LAST_YEAR) ||
               (in_ch.in_year < EPOCH_YEAR) ||
               (in_ch.in_month < MONTH_FIRST) || (in_ch.in_month > MONTH_LAST))) begin
            st_nxt    = ST_RANGE;
            state_nxt = S_DONE;
          end
        end
      end
      S_YEAR: begin
        if (cmd_r == CMD_TO_DAYS) begin
          if (cal_year == y_r) begin
            if ((d_r == 5'd0) || (d_r > mlen)) begin
              st_nxt    = ST_BAD_DAY;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_MONTH;
            end
          end else begin
            acc_nxt       = alu_res;
            ovf_nxt       = ovf_r | alu_res[17];
            wd_nxt        = wday_add(wd_r, ymod);
            cal_ctrl.step = 1'b1;
          end
        end else begin
          if (cal_year > LAST_YEAR) begin
            st_nxt    = ST_RANGE;
            state_nxt = S_DONE;
          end else if (!alu_carry) begin
            acc_nxt       = alu_res;
            wd_nxt        = wday_add(wd_r, ymod);
            cal_ctrl.step = 1'b1;
          end else if (cal_year < FIRST_YEAR) begin
            st_nxt    = ST_RANGE;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MONTH;
          end
        end
      end
      S_MONTH: begin
        if (cmd_r == CMD_TO_DAYS) begin
          if (mo_r == m_r) begin
            state_nxt = S_DAYS;
          end else begin
            acc_nxt = alu_res;
            ovf_nxt = ovf_r | alu_res[17];
            wd_nxt  = wday_add(wd_r, mlen);
            mo_nxt  = mo_r + 4'd1;
          end
        end else begin
          if (!alu_carry) begin
            acc_nxt = alu_res;
            wd_nxt  = wday_add(wd_r, mlen);
            mo_nxt  = mo_r + 4'd1;
          end else begin
            state_nxt = S_DAYS;
          end
        end
      end
      S_DAYS: begin
        if (cmd_r == CMD_TO_DAYS) begin
          acc_nxt = alu_res;
          wd_nxt  = wday_add(wd_r, d_r - 5'd1);
          if (ovf_r || alu_res[17]) begin
            st_nxt = ST_RANGE;
          end
        end else begin
          wd_nxt = wday_add(wd_r, acc_r[4:0]);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    y_r   <= y_nxt;
    m_r   <= m_nxt;
    d_r   <= d_nxt;
    n_r   <= n_nxt;
    acc_r <= acc_nxt;
    mo_r  <= mo_nxt;
    wd_r  <= wd_nxt;
    ovf_r <= ovf_nxt;
    st_r  <= st_nxt;
  end

  assign ok = (st_r == ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= st_r;
      out_wday_r   <= ok ? wd_r : '0;
      out_year_r   <= ok ? cal_year : '0;
      if (!ok) begin
        out_num_r   <= '0;
        out_month_r <= '0;
        out_day_r   <= '0;
      end else if (cmd_r == CMD_TO_DATE) begin
        out_num_r   <= n_r;
        out_month_r <= mo_r;
        out_day_r   <= acc_r[4:0] + 5'd1;
      end else begin
        out_num_r   <= acc_r[16:0];
        out_month_r <= m_r;
        out_day_r   <= d_r;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_day_number = out_num_r;
  assign out_ch.out_year       = out_year_r;
  assign out_ch.out_month      = out_month_r;
  assign out_ch.out_day        = out_day_r;
  assign out_ch.weekday        = out_wday_r;
  assign out_ch.status         = out_status_r;

endmodule

// ===== rtl/core/cdc_chk.sv =====
// Port-level checker for the calendar date converter and the bind that attaches it.
// Depends on cdc_pkg for field types and status codes.
module cdc_chk import cdc_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input daynum_t out_day_number,
  input year_t   out_year,
  input month_t  out_month,
  input day_t    out_day,
  input wday_t   weekday,
  input status_t status
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after an item was accepted");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_day_number) && $stable(status)))
    else $error("result item changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (status != ST_OK)) |->
      ((out_day_number == '0) && (out_year == '0) && (out_month == '0) &&
       (out_day == '0) && (weekday == '0)))
    else $error("failed result carries nonzero fields");

  a_ok_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (status == ST_OK)) |->
      ((weekday <= 3'd6) && (out_month >= MONTH_FIRST) && (out_month <= MONTH_LAST) &&
       (out_day != 5'd0) && (out_year >= FIRST_YEAR) && (out_year <= LAST_YEAR)))
    else $error("good result holds an impossible date");

endmodule

bind calendar_date_day_number_converter cdc_chk u_cdc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_day_number (out_ch.out_day_number),
  .out_year       (out_ch.out_year),
  .out_month      (out_ch.out_month),
  .out_day        (out_ch.out_day),
  .weekday        (out_ch.weekday),
  .status         (out_ch.status)
);
